@@ sv/tsc_pkg.sv @@
package tsc_pkg;

	localparam int MAX_LEN_DEF = 30;
	localparam int LEN_W       = 5;
	localparam int SUM_W       = 12;
	localparam int PAD_TARGET  = 25;
	localparam int HDR_LEN     = 5;
	localparam int ALPHA_LEN   = 62;
	localparam int STAGE_CNT   = 5;

	localparam logic [5:0] NOT_ALPHA = 6'd62;
	localparam logic [6:0] CH_ZERO   = 7'h30;
	localparam logic [6:0] CH_ONE    = 7'h31;
	localparam logic [6:0] CH_NINE   = 7'h39;
	localparam logic [6:0] CH_LA     = 7'h61;
	localparam logic [6:0] CH_LZ     = 7'h7a;
	localparam logic [6:0] CH_UA     = 7'h41;
	localparam logic [6:0] CH_UZ     = 7'h5a;
	localparam logic [6:0] BAD_CHAR  = CH_NINE;

	localparam logic [8*ALPHA_LEN-1:0] FINAL_TAB =
		"X1Hx6B2NcUYn9ibwCIhMuV7GtAa8WjQJmEyvlsTOgK50ZdkPoSe3DzpLf4FqRr";
	localparam logic [8*ALPHA_LEN-1:0] STAGE_TAB0 =
		"UXyDVxzdL1EeWKfowQMp3nv0RAa9CJmcNblFqTkrO2YIgBsZ8htS7j4u6PiH5G";
	localparam logic [8*ALPHA_LEN-1:0] STAGE_TAB1 =
		"yDVzdL1EeWfQxMp3nBc0RgAaT9CJmI4NbGloFKqXvkrwO2YHUZ5htS7ju6Pi8s";
	localparam logic [8*ALPHA_LEN-1:0] STAGE_TAB2 =
		"1Hx62NcUnibCIhMuV7GXtADyBaWjwJ8rfY9EvlsTOkK50dPQmoSe3Lgzp4ZFqR";
	localparam logic [8*ALPHA_LEN-1:0] STAGE_TAB3 =
		"DzdL1EeWKfUmwQMp3nv0RAVao9CxJcNXb4lFHTykZrO2YI5gBGsq8htS7jPu6i";
	localparam logic [8*ALPHA_LEN-1:0] STAGE_TAB4 =
		"Hx2NcUnbCIhM1u7GXt6ADiyBdaWjwJ8rfYvlsTOVk9K5R0PQmqoSeE3Lgzp4ZF";

	typedef enum logic [1:0] {
		K_TOK = 2'd0,
		K_PAD = 2'd1,
		K_HDR = 2'd2,
		K_ERR = 2'd3
	} kind_t;

	typedef struct packed {
		logic             load;
		logic             prep;
		logic             valid;
		kind_t            kind;
		logic [LEN_W-1:0] idx;
		logic [2:0]       pos;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             ovf;
		logic             pipe_busy;
	} stat_t;

	function automatic logic [5:0] alpha_idx(input logic [6:0] c);
		logic [5:0] k;
		k = NOT_ALPHA;
		if (c >= CH_ONE && c <= CH_NINE) begin
			k = 6'(c - CH_ONE);
		end else if (c == CH_ZERO) begin
			k = 6'd9;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			k = 6'(c - CH_LA) + 6'd10;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			k = 6'(c - CH_UA) + 6'd36;
		end
		return k;
	endfunction

	function automatic logic [6:0] tab_char(input logic [8*ALPHA_LEN-1:0] s,
		input logic [5:0] k);
		logic [5:0] kk;
		kk = (k < 6'(ALPHA_LEN)) ? k : 6'd0;
		return s[8*(ALPHA_LEN-1-int'(kk)) +: 7];
	endfunction

	function automatic logic [8*ALPHA_LEN-1:0] stage_row(input logic [2:0] sel);
		logic [8*ALPHA_LEN-1:0] r;
		case (sel)
			3'd0:    r = STAGE_TAB0;
			3'd1:    r = STAGE_TAB1;
			3'd2:    r = STAGE_TAB2;
			3'd3:    r = STAGE_TAB3;
			3'd4:    r = STAGE_TAB4;
			default: r = STAGE_TAB0;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] stage_sub(input logic [6:0] c, input logic [2:0] pos);
		logic [5:0] k;
		logic [6:0] r;
		k = alpha_idx(c);
		if (k == NOT_ALPHA) begin
			r = c;
		end else begin
			r = tab_char(stage_row(pos), k);
		end
		return r;
	endfunction

	function automatic logic [6:0] final_sub(input logic [6:0] c);
		logic [5:0] k;
		logic [6:0] r;
		k = alpha_idx(c);
		if (k == NOT_ALPHA) begin
			r = BAD_CHAR;
		end else begin
			r = tab_char(FINAL_TAB, k);
		end
		return r;
	endfunction

	function automatic logic [1:0] sum_mod3(input logic [SUM_W-1:0] s);
		logic [4:0] v;
		v = '0;
		for (int i = 0; i < SUM_W / 2; i++) begin
			v = v + 5'(s[2*i +: 2]);
		end
		if (v >= 5'd12) v = v - 5'd12;
		if (v >= 5'd6)  v = v - 5'd6;
		if (v >= 5'd3)  v = v - 5'd3;
		return v[1:0];
	endfunction

	function automatic logic [2:0] sum_mod5(input logic [SUM_W-1:0] s);
		logic [5:0] v;
		v = '0;
		for (int i = 0; i < SUM_W / 4; i++) begin
			v = v + 6'(s[4*i +: 4]);
		end
		if (v >= 6'd40) v = v - 6'd40;
		if (v >= 6'd20) v = v - 6'd20;
		if (v >= 6'd10) v = v - 6'd10;
		if (v >= 6'd5)  v = v - 6'd5;
		return v[2:0];
	endfunction

	function automatic logic [1:0] len_tens(input logic [LEN_W-1:0] v);
		logic [1:0] t;
		if (v >= LEN_W'(30)) begin
			t = 2'd3;
		end else if (v >= LEN_W'(20)) begin
			t = 2'd2;
		end else if (v >= LEN_W'(10)) begin
			t = 2'd1;
		end else begin
			t = 2'd0;
		end
		return t;
	endfunction

	function automatic logic [3:0] len_ones(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		case (len_tens(v))
			2'd3:    r = v - LEN_W'(30);
			2'd2:    r = v - LEN_W'(20);
			2'd1:    r = v - LEN_W'(10);
			default: r = v;
		endcase
		return r[3:0];
	endfunction

	function automatic logic [3:0] ofs_tens(input logic [2:0] m5);
		logic [3:0] t;
		case (m5)
			3'd2:    t = 4'd1;
			3'd3:    t = 4'd1;
			3'd4:    t = 4'd2;
			default: t = 4'd0;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] ofs_ones(input logic [2:0] m5);
		logic [3:0] o;
		case (m5)
			3'd1:    o = 4'd6;
			3'd2:    o = 4'd2;
			3'd3:    o = 4'd8;
			3'd4:    o = 4'd4;
			default: o = 4'd0;
		endcase
		return o;
	endfunction

endpackage

@@ sv/tsc_ctrl.sv @@
module tsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           in_last,
	input  tsc_pkg::stat_t stat,
	output logic           busy,
	output tsc_pkg::cmd_t  cmd
);
	import tsc_pkg::*;

	typedef enum logic [5:0] {
		S_LOAD = 6'b000001,
		S_PREP = 6'b000010,
		S_TOK  = 6'b000100,
		S_PAD  = 6'b001000,
		S_HDR  = 6'b010000,
		S_ERR  = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [LEN_W-1:0] k_q, k_d;
	logic [2:0]       pos_q, pos_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] pad_q, pad_d;
	logic             accept;
	logic [2:0]       pos_inc;

	assign busy    = (state_q != S_LOAD) || stat.pipe_busy;
	assign accept  = start && !busy;
	assign pos_inc = (pos_q == 3'(STAGE_CNT - 1)) ? 3'd0 : pos_q + 3'd1;

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		pos_d     = pos_q;
		len_d     = len_q;
		pad_d     = pad_q;
		cmd       = '0;
		cmd.kind  = K_TOK;
		cmd.load  = accept;
		cmd.idx   = k_q;
		cmd.pos   = pos_q;
		case (state_q)
			S_LOAD: begin
				if (accept && in_last) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				k_d      = '0;
				pos_d    = 3'd1;
				len_d    = stat.len;
				pad_d    = (stat.len < LEN_W'(PAD_TARGET)) ?
					LEN_W'(PAD_TARGET) - stat.len : '0;
				state_d  = stat.ovf ? S_ERR : S_TOK;
			end
			S_ERR: begin
				cmd.valid = 1'b1;
				cmd.kind  = K_ERR;
				cmd.last  = 1'b1;
				state_d   = S_LOAD;
			end
			S_TOK: begin
				cmd.valid = 1'b1;
				cmd.kind  = K_TOK;
				if (k_q == len_q - LEN_W'(1)) begin
					k_d     = '0;
					pos_d   = 3'd1;
					state_d = (pad_q != '0) ? S_PAD : S_HDR;
				end else begin
					k_d   = k_q + LEN_W'(1);
					pos_d = pos_inc;
				end
			end
			S_PAD: begin
				cmd.valid = 1'b1;
				cmd.kind  = K_PAD;
				if (k_q == pad_q - LEN_W'(1)) begin
					k_d     = '0;
					pos_d   = 3'd1;
					state_d = S_HDR;
				end else begin
					k_d = k_q + LEN_W'(1);
				end
			end
			S_HDR: begin
				cmd.valid = 1'b1;
				cmd.kind  = K_HDR;
				if (k_q == LEN_W'(HDR_LEN - 1)) begin
					cmd.last = 1'b1;
					k_d      = '0;
					state_d  = S_LOAD;
				end else begin
					k_d   = k_q + LEN_W'(1);
					pos_d = pos_inc;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			k_q     <= '0;
			pos_q   <= 3'd1;
			len_q   <= '0;
			pad_q   <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			pad_q   <= pad_d;
		end
	end

endmodule

@@ sv/tsc_dp.sv @@
module tsc_dp #(
	parameter int MAX_LEN = tsc_pkg::MAX_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [6:0]     in_char,
	input  tsc_pkg::cmd_t  cmd,
	output tsc_pkg::stat_t stat,
	output logic           strobe,
	output logic [6:0]     out_char,
	output logic           out_last,
	output logic           too_long
);
	import tsc_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int IW = $clog2(MAX_LEN);

	logic [6:0]       store_q [MAX_LEN];
	logic [CW-1:0]    count_q;
	logic [SUM_W-1:0] sum_q;
	logic             ovf_q;
	logic [1:0]       tsel_q;
	logic [2:0]       m5_q;
	logic [LEN_W-1:0] len_q;

	logic             v_s1, last_s1, err_s1;
	logic [6:0]       char_s1;
	logic             v_s2, last_s2, err_s2;
	logic [6:0]       char_s2;

	logic [4:0]       post;
	logic [5:0]       pad_idx;
	logic [6:0]       tok_c, hdr_c, s1_c;

	assign post    = 5'({m5_q, 2'b00}) + 5'({m5_q, 1'b0});
	assign pad_idx = 6'(post) + 6'(cmd.idx);
	assign tok_c   = store_q[cmd.idx[IW-1:0]];

	always_comb begin
		case (cmd.idx)
			LEN_W'(0): hdr_c = CH_ZERO + 7'(tsel_q);
			LEN_W'(1): hdr_c = CH_ZERO + 7'(ofs_tens(m5_q));
			LEN_W'(2): hdr_c = CH_ZERO + 7'(ofs_ones(m5_q));
			LEN_W'(3): hdr_c = CH_ZERO + 7'(len_tens(len_q));
			default:   hdr_c = CH_ZERO + 7'(len_ones(len_q));
		endcase
	end

	always_comb begin
		case (cmd.kind)
			K_TOK:   s1_c = stage_sub(tok_c, cmd.pos);
			K_PAD:   s1_c = tab_char(stage_row(3'(tsel_q)), pad_idx);
			K_HDR:   s1_c = stage_sub(hdr_c, cmd.pos);
			default: s1_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (count_q >= CW'(MAX_LEN)) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
					sum_q   <= sum_q + SUM_W'(in_char);
				end
			end else if (cmd.prep) begin
				count_q <= '0;
				sum_q   <= '0;
				ovf_q   <= 1'b0;
			end
			v_s1 <= cmd.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < CW'(MAX_LEN))) begin
			store_q[count_q[IW-1:0]] <= in_char;
		end
		if (cmd.prep) begin
			tsel_q <= sum_mod3(sum_q);
			m5_q   <= sum_mod5(sum_q);
			len_q  <= LEN_W'(count_q);
		end
		char_s1 <= s1_c;
		last_s1 <= cmd.last;
		err_s1  <= (cmd.kind == K_ERR);
		char_s2 <= err_s1 ? 7'd0 : final_sub(char_s1);
		last_s2 <= last_s1;
		err_s2  <= err_s1;
	end

	assign stat.len       = LEN_W'(count_q);
	assign stat.ovf       = ovf_q;
	assign stat.pipe_busy = v_s1;

	assign strobe   = v_s2;
	assign out_char = char_s2;
	assign out_last = last_s2;
	assign too_long = err_s2;

endmodule

@@ sv/table_substitution_token_scrambler_core.sv @@
// A token character is taken when start is high and busy is low; characters
// before the last give no result. After the last character the controller passes
// S_PREP, then results, registered in s1 and s2, come one a cycle: len +
// max(0, 25 - len) + 5 results, or a single error beat. busy stays high from the last
// beat until the final result is on the ports. Reset is asynchronous and empties the
// token; results are never held off.
module table_substitution_token_scrambler_core #(
	parameter int MAX_LEN = tsc_pkg::MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [6:0] in_char,
	input  logic       in_last,
	output logic       busy,
	output logic       strobe,
	output logic [6:0] out_char,
	output logic       out_last,
	output logic       too_long
);
	import tsc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	tsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.in_last (in_last),
		.stat    (stat),
		.busy    (busy),
		.cmd     (cmd)
	);

	tsc_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_char  (in_char),
		.cmd      (cmd),
		.stat     (stat),
		.strobe   (strobe),
		.out_char (out_char),
		.out_last (out_last),
		.too_long (too_long)
	);

endmodule

@@ test/scrambler_checker.sv @@
module scrambler_checker #(
	parameter int MAX_LEN = tsc_pkg::MAX_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  logic [6:0]      in_char,
	input  logic            in_last,
	input  logic            strobe,
	input  logic [6:0]      out_char,
	input  logic            out_last,
	input  logic            too_long,
	output int unsigned     outstanding,
	output int unsigned     fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
		logic       err;
	} enc_beat_t;

	enc_beat_t   enc_q[$];
	enc_beat_t   got;
	enc_beat_t   want;
	logic [6:0]  tok_chars[MAX_LEN];
	logic [6:0]  digit;
	int unsigned tok_len;
	int unsigned tok_sum;
	int unsigned pad_sel;
	int unsigned pad_ofs;
	int unsigned pad_len;
	int unsigned err_cnt;
	bit          tok_ovf;
	string       pad_row;

	function automatic int alpha_pos(input logic [6:0] c);
		if (c >= "1" && c <= "9") return int'(c) - int'("1");
		if (c == "0") return 9;
		if (c >= "a" && c <= "z") return 10 + int'(c) - int'("a");
		if (c >= "A" && c <= "Z") return 36 + int'(c) - int'("A");
		return 62;
	endfunction

	function automatic string stage_row(input int r);
		case (r)
			0:       return "UXyDVxzdL1EeWKfowQMp3nv0RAa9CJmcNblFqTkrO2YIgBsZ8htS7j4u6PiH5G";
			1:       return "yDVzdL1EeWfQxMp3nBc0RgAaT9CJmI4NbGloFKqXvkrwO2YHUZ5htS7ju6Pi8s";
			2:       return "1Hx62NcUnibCIhMuV7GXtADyBaWjwJ8rfY9EvlsTOkK50dPQmoSe3Lgzp4ZFqR";
			3:       return "DzdL1EeWKfUmwQMp3nv0RAVao9CxJcNXb4lFHTykZrO2YI5gBGsq8htS7jPu6i";
			default: return "Hx2NcUnbCIhM1u7GXt6ADiyBdaWjwJ8rfYvlsTOVk9K5R0PQmqoSeE3Lgzp4ZF";
		endcase
	endfunction

	function automatic logic [6:0] stage_map(input logic [6:0] c, input int r);
		int    k;
		string row;
		k = alpha_pos(c);
		if (k >= 62) return c;
		row = stage_row(r);
		return 7'(row[k]);
	endfunction

	function automatic logic [6:0] final_map(input logic [6:0] c);
		int    k;
		string row;
		k = alpha_pos(c);
		if (k >= 62) return tsc_pkg::BAD_CHAR;
		row = "X1Hx6B2NcUYn9ibwCIhMuV7GtAa8WjQJmEyvlsTOgK50ZdkPoSe3DzpLf4FqRr";
		return 7'(row[k]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q.delete();
			tok_len = 0;
			tok_sum = 0;
			tok_ovf = 0;
			err_cnt = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (strobe) begin
				got = '{ch: out_char, last: out_last, err: too_long};
				if (enc_q.size() == 0) begin
					$error("unexpected beat: out_char %h out_last %b too_long %b",
						got.ch, got.last, got.err);
					err_cnt++;
				end else begin
					want = enc_q.pop_front();
					if (got.ch !== want.ch) begin
						$error("out_char expected %h got %h", want.ch, got.ch);
						err_cnt++;
					end
					if (got.last !== want.last) begin
						$error("out_last expected %b got %b", want.last, got.last);
						err_cnt++;
					end
					if (got.err !== want.err) begin
						$error("too_long expected %b got %b", want.err, got.err);
						err_cnt++;
					end
				end
			end
			if (start && !busy) begin
				if (tok_len >= MAX_LEN) begin
					tok_ovf = 1;
				end else begin
					tok_chars[tok_len] = in_char;
					tok_len++;
					tok_sum = (tok_sum + in_char) & 12'hFFF;
				end
				if (in_last) begin
					if (tok_ovf) begin
						enc_q.push_back('{ch: 7'h00, last: 1'b1, err: 1'b1});
					end else begin
						pad_sel = tok_sum % 3;
						pad_ofs = 6 * (tok_sum % 5);
						pad_len = (tok_len < 25) ? 25 - tok_len : 0;
						pad_row = stage_row(pad_sel);
						for (int i = 0; i < tok_len; i++) begin
							enc_q.push_back('{ch: final_map(stage_map(tok_chars[i], (i + 1) % 5)),
								last: 1'b0, err: 1'b0});
						end
						for (int i = 0; i < pad_len; i++) begin
							digit = 7'(pad_row[pad_ofs + i]);
							enc_q.push_back('{ch: final_map(digit), last: 1'b0, err: 1'b0});
						end
						for (int i = 0; i < 5; i++) begin
							case (i)
								0:       digit = tsc_pkg::CH_ZERO + 7'(pad_sel);
								1:       digit = tsc_pkg::CH_ZERO + 7'(pad_ofs / 10);
								2:       digit = tsc_pkg::CH_ZERO + 7'(pad_ofs % 10);
								3:       digit = tsc_pkg::CH_ZERO + 7'((tok_len / 10) % 10);
								default: digit = tsc_pkg::CH_ZERO + 7'(tok_len % 10);
							endcase
							enc_q.push_back('{ch: final_map(stage_map(digit, (i + 1) % 5)),
								last: (i == 4), err: 1'b0});
						end
					end
					tok_len = 0;
					tok_sum = 0;
					tok_ovf = 0;
				end
			end
			outstanding <= enc_q.size();
			fail_count <= err_cnt;
		end
	end

endmodule

@@ test/tb_table_substitution_token_scrambler_core.sv @@
module tb_table_substitution_token_scrambler_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [6:0]  in_char;
	logic        in_last;
	logic        busy;
	logic        strobe;
	logic [6:0]  out_char;
	logic        out_last;
	logic        too_long;
	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned sent;
	int unsigned tok_len;

	table_substitution_token_scrambler_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.in_char  (in_char),
		.in_last  (in_last),
		.busy     (busy),
		.strobe   (strobe),
		.out_char (out_char),
		.out_last (out_last),
		.too_long (too_long)
	);

	scrambler_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.in_char     (in_char),
		.in_last     (in_last),
		.strobe      (strobe),
		.out_char    (out_char),
		.out_last    (out_last),
		.too_long    (too_long),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	function automatic logic [6:0] alnum_char();
		case ($urandom_range(0, 2))
			0:       return tsc_pkg::CH_ZERO + 7'($urandom_range(0, 9));
			1:       return tsc_pkg::CH_LA + 7'($urandom_range(0, 25));
			default: return tsc_pkg::CH_UA + 7'($urandom_range(0, 25));
		endcase
	endfunction

	task automatic send_beat(input logic [6:0] c, input logic l, input bit burst);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			start <= 1'b0;
			in_char <= 7'($urandom_range(1, 127));
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		in_char <= c;
		in_last <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_token(input int unsigned len);
		bit alnum;
		bit burst;
		alnum = ($urandom_range(0, 4) != 0);
		burst = ($urandom_range(0, 3) == 0);
		for (int unsigned i = 0; i < len; i++) begin
			send_beat(alnum ? alnum_char() : 7'($urandom_range(1, 127)), i == len - 1, burst);
		end
	endtask

	// hold off until every pending beat has come out
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		in_char <= 7'h01;
		in_last <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(7'h7F, 1'b1, 1'b0);
		drain();
		send_beat(7'h01, 1'b0, 1'b1);
		send_beat(tsc_pkg::CH_ZERO, 1'b0, 1'b1);
		send_beat(tsc_pkg::CH_NINE, 1'b0, 1'b0);
		send_beat(tsc_pkg::CH_LA, 1'b0, 1'b0);
		send_beat(tsc_pkg::CH_LZ, 1'b0, 1'b1);
		send_beat(tsc_pkg::CH_UA, 1'b0, 1'b0);
		send_beat(tsc_pkg::CH_UZ, 1'b0, 1'b0);
		send_beat(7'h40, 1'b0, 1'b0);
		send_beat(7'h7B, 1'b1, 1'b0);
		send_beat(tsc_pkg::CH_ONE, 1'b0, 1'b1);
		send_beat(7'h2F, 1'b1, 1'b1);

		sent = 0;
		while (sent < 260) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: tok_len = $urandom_range(1, 12);
				6, 7:             tok_len = $urandom_range(13, 30);
				8:                tok_len = $urandom_range(24, 30);
				default:          tok_len = $urandom_range(31, 34);
			endcase
			send_token(tok_len);
			sent += tok_len;
			if ($urandom_range(0, 5) == 0) drain();
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
